[rtl/gcf_pkg.sv]
// Shared types and constants for the gripper contact-force controller.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package gcf_pkg;

    // Field widths
    localparam int ANGLE_W    = 24;
    localparam int FORCE_W    = 22;
    localparam int DT_W       = 20;
    localparam int OPCODE_W   = 3;
    localparam int PHASE_W    = 2;
    localparam int EVENT_W    = 2;

    // Stream bus widths and packing
    localparam int S_TDATA_W  = 72;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 1;
    localparam int ANGLE_LSB  = 0;
    localparam int FORCE_LSB  = ANGLE_LSB + ANGLE_W;
    localparam int DT_LSB     = FORCE_LSB + FORCE_W;
    localparam int PHASE_LSB  = ANGLE_W;
    localparam int EVENT_LSB  = PHASE_LSB + PHASE_W;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 24;
    localparam int NUM_REGS    = 8;
    localparam int REG_IDX_W   = 3;

    localparam logic [REG_IDX_W-1:0] REG_APPROACH_SPEED    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CONTACT_THRESHOLD = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BACKOFF_DISTANCE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FORCE_TARGET      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PROPORTIONAL_GAIN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_GAIN     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_LIMIT    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_MAX_RATE          = 3'd7;

    // Input opcodes
    localparam logic [OPCODE_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_NEW_GOAL   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_CANCEL     = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_ACTIVATE   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DEACTIVATE = 3'd4;

    // Phases and goal events
    localparam logic [PHASE_W-1:0] PHASE_APPROACH = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_BACKOFF  = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_HOLD     = 2'd2;

    localparam logic [EVENT_W-1:0] EVENT_NONE      = 2'd0;
    localparam logic [EVENT_W-1:0] EVENT_SUCCEEDED = 2'd1;
    localparam logic [EVENT_W-1:0] EVENT_CANCELED  = 2'd2;
    localparam logic [EVENT_W-1:0] EVENT_ABORTED   = 2'd3;

    // Depth of the queue between front and back
    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_TICK,
        KIND_GOAL,
        KIND_CANCEL,
        KIND_ACTIVATE,
        KIND_DEACTIVATE
    } kind_t;

    // One classified item as it waits in the queue
    typedef struct packed {
        kind_t                     kind;
        logic                      dt_zero;
        logic signed [ANGLE_W-1:0] joint_angle;
        logic signed [FORCE_W-1:0] grip_force;
        logic [DT_W-1:0]           tick_time;
    } item_t;

    typedef struct packed {
        logic signed [23:0] approach_speed;
        logic [20:0]        contact_threshold;
        logic [22:0]        backoff_distance;
        logic [20:0]        force_target;
        logic [23:0]        proportional_gain;
        logic [23:0]        integral_gain;
        logic [22:0]        integral_limit;
        logic [22:0]        max_rate;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        approach_speed:    -24'sd209715,
        contact_threshold: 21'd4000,
        backoff_distance:  23'd52429,
        force_target:      21'd3200,
        proportional_gain: 24'd66,
        integral_gain:     24'd33,
        integral_limit:    23'd104858,
        max_rate:          23'd524288
    };

endpackage

[rtl/gcf_front.sv]
// Front end: accepts stream transfers, classifies the opcode and queues items.
// Depends on gcf_pkg.
`timescale 1ns / 1ps

module gcf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gcf_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [gcf_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          pop,
    output logic                          head_valid,
    output gcf_pkg::item_t                head
);
    import gcf_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    item_t            entry_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             do_pop;
    item_t            incoming;

    assign s_tready   = (count_reg != CNT_W'(QDEPTH));
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb begin
        incoming.joint_angle = $signed(s_tdata[ANGLE_LSB +: ANGLE_W]);
        incoming.grip_force  = $signed(s_tdata[FORCE_LSB +: FORCE_W]);
        incoming.tick_time   = s_tdata[DT_LSB +: DT_W];
        incoming.dt_zero     = (s_tdata[DT_LSB +: DT_W] == '0);
        unique case (s_tuser[OPCODE_W-1:0])
            OP_TICK:       incoming.kind = KIND_TICK;
            OP_NEW_GOAL:   incoming.kind = KIND_GOAL;
            OP_CANCEL:     incoming.kind = KIND_CANCEL;
            OP_ACTIVATE:   incoming.kind = KIND_ACTIVATE;
            OP_DEACTIVATE: incoming.kind = KIND_DEACTIVATE;
            default:       incoming.kind = KIND_NOP;
        endcase
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

[rtl/gcf_back.sv]
// Back end: phase state machine, PI force loop on one shared multiplier,
// and the registered result stage. Depends on gcf_pkg.
`timescale 1ns / 1ps

module gcf_back #(
    parameter int RAD_PER_G_SHIFT = 13,
    parameter int DEADBAND_FORCE  = 800
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gcf_pkg::cfg_t                 cfg,
    input  logic                          head_valid,
    input  gcf_pkg::item_t                head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gcf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [gcf_pkg::M_TUSER_W-1:0] m_tuser
);
    import gcf_pkg::*;

    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int WIDE_W = 48;
    localparam int SMAG_W = 47;
    localparam int LIM_W  = 23;
    localparam int EMAG_W = FORCE_W;
    localparam int PLO_W  = 20;
    localparam logic [EMAG_W-1:0] DEADBAND_C = EMAG_W'(DEADBAND_FORCE);

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_EXEC = 12'b0000_0000_0010,
        ST_MOVE = 12'b0000_0000_0100,
        ST_H1   = 12'b0000_0000_1000,
        ST_H2   = 12'b0000_0001_0000,
        ST_H3   = 12'b0000_0010_0000,
        ST_H4   = 12'b0000_0100_0000,
        ST_H5   = 12'b0000_1000_0000,
        ST_H6   = 12'b0001_0000_0000,
        ST_H7   = 12'b0010_0000_0000,
        ST_H8   = 12'b0100_0000_0000,
        ST_OUT  = 12'b1000_0000_0000
    } state_t;

    function automatic logic signed [ANGLE_W-1:0] sat_angle(
        input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = 48'sd8388607;
        lo = -48'sd8388608;
        if (v > hi) begin
            return ANGLE_W'(hi);
        end else if (v < lo) begin
            return ANGLE_W'(lo);
        end
        return ANGLE_W'(v);
    endfunction

    // Control state
    state_t                    state_reg, state_next;
    logic [PHASE_W-1:0]        phase_reg, phase_next;
    logic signed [ANGLE_W-1:0] integral_acc_reg, integral_acc_next;
    logic signed [ANGLE_W-1:0] command_reg, command_next;
    logic                      active_flag_reg, active_flag_next;
    logic                      goal_open_reg, goal_open_next;
    logic                      cancel_pending_reg, cancel_pending_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    // Payload
    logic signed [ANGLE_W-1:0] backoff_goal_reg, backoff_goal_next;
    item_t                     item_reg, item_next;
    logic [EVENT_W-1:0]        event_reg, event_next;
    logic                      valid_reg, valid_next;
    logic [PROD_W-1:0]         prod_reg;
    logic                      e_neg_reg, e_neg_next;
    logic [EMAG_W-1:0]         e_mag_reg, e_mag_next;
    logic [PLO_W-1:0]          plo_reg, plo_next;
    logic [45:0]               hi_reg, hi_next;
    logic signed [WIDE_W-1:0]  s_reg, s_next;
    logic [SMAG_W-1:0]         smag_reg, smag_next;
    logic                      s_neg_reg, s_neg_next;
    logic [LIM_W-1:0]          lim_reg, lim_next;
    logic signed [ANGLE_W-1:0] dq_reg, dq_next;
    logic [M_TDATA_W-1:0]      m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]      m_tuser_reg, m_tuser_next;

    // Shared multiplier
    logic [MUL_W-1:0]          mul_a, mul_b;
    logic [PROD_W-1:0]         mul_p;

    // Datapath terms
    logic                      speed_neg;
    logic [ANGLE_W-1:0]        speed_mag;
    logic signed [WIDE_W-1:0]  q48, acc48, mv48, mv_s48, ilim48, e48;
    logic signed [WIDE_W-1:0]  inc48, acc_sum48, kpe48, s_calc48, dq48;
    logic [46:0]               inc_mag;
    logic [WIDE_W-1:0]         s_abs;
    logic [LIM_W-1:0]          dq_mag;
    logic signed [22:0]        force23, thr23;
    logic                      goal_left;

    assign speed_neg = cfg.approach_speed[ANGLE_W-1];
    assign speed_mag = speed_neg ? (~cfg.approach_speed + 24'd1) : cfg.approach_speed;

    assign q48    = {{(WIDE_W-ANGLE_W){item_reg.joint_angle[ANGLE_W-1]}}, item_reg.joint_angle};
    assign acc48  = {{(WIDE_W-ANGLE_W){integral_acc_reg[ANGLE_W-1]}}, integral_acc_reg};
    assign ilim48 = {{(WIDE_W-LIM_W){1'b0}}, cfg.integral_limit};
    assign mv48   = {{(WIDE_W-LIM_W){1'b0}}, prod_reg[42:20]};
    assign mv_s48 = speed_neg ? -mv48 : mv48;
    assign e48    = {{(WIDE_W-21){1'b0}}, cfg.force_target}
                  - {{(WIDE_W-FORCE_W){item_reg.grip_force[FORCE_W-1]}}, item_reg.grip_force};
    assign force23 = {item_reg.grip_force[FORCE_W-1], item_reg.grip_force};
    assign thr23   = {2'b00, cfg.contact_threshold};

    assign inc_mag   = {1'b0, hi_reg} + {27'b0, prod_reg[39:20]};
    assign inc48     = {1'b0, inc_mag};
    assign acc_sum48 = e_neg_reg ? (acc48 - inc48) : (acc48 + inc48);
    assign kpe48     = {2'b00, prod_reg[45:0]};
    assign s_calc48  = e_neg_reg ? (acc48 - kpe48) : (acc48 + kpe48);
    assign s_abs     = s_reg[WIDE_W-1] ? (~s_reg + 48'd1) : s_reg;
    assign dq_mag    = (smag_reg > {{(SMAG_W-LIM_W){1'b0}}, lim_reg}) ? lim_reg
                                                                       : smag_reg[LIM_W-1:0];
    assign dq48      = {{(WIDE_W-ANGLE_W){dq_reg[ANGLE_W-1]}}, dq_reg};

    // Operand selection for the one multiplier; the product is registered.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_EXEC: begin
                mul_a = MUL_W'(speed_mag);
                mul_b = MUL_W'(item_reg.tick_time);
            end
            ST_H1: begin
                mul_a = MUL_W'(cfg.integral_gain);
                mul_b = MUL_W'(e_mag_reg);
            end
            ST_H2: begin
                mul_a = MUL_W'(prod_reg[45:20]);
                mul_b = MUL_W'(item_reg.tick_time);
            end
            ST_H3: begin
                mul_a = MUL_W'(plo_reg);
                mul_b = MUL_W'(item_reg.tick_time);
            end
            ST_H4: begin
                mul_a = MUL_W'(cfg.proportional_gain);
                mul_b = MUL_W'(e_mag_reg);
            end
            ST_H5: begin
                mul_a = MUL_W'(cfg.max_rate);
                mul_b = MUL_W'(item_reg.tick_time);
            end
            default: begin
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb begin
        state_next          = state_reg;
        phase_next          = phase_reg;
        integral_acc_next   = integral_acc_reg;
        command_next        = command_reg;
        active_flag_next    = active_flag_reg;
        goal_open_next      = goal_open_reg;
        cancel_pending_next = cancel_pending_reg;
        backoff_goal_next   = backoff_goal_reg;
        item_next           = item_reg;
        event_next          = event_reg;
        valid_next          = valid_reg;
        e_neg_next          = e_neg_reg;
        e_mag_next          = e_mag_reg;
        plo_next            = plo_reg;
        hi_next             = hi_reg;
        s_next              = s_reg;
        smag_next           = smag_reg;
        s_neg_next          = s_neg_reg;
        lim_next            = lim_reg;
        dq_next             = dq_reg;
        m_tdata_next        = m_tdata_reg;
        m_tuser_next        = m_tuser_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        goal_left           = goal_open_reg;
        pop                 = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    pop        = 1'b1;
                    item_next  = head;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                event_next = EVENT_NONE;
                valid_next = 1'b0;
                state_next = ST_OUT;
                e_neg_next = e48[WIDE_W-1];
                e_mag_next = e48[WIDE_W-1] ? EMAG_W'(-e48) : EMAG_W'(e48);
                unique case (item_reg.kind)
                    KIND_TICK: begin
                        if (active_flag_reg) begin
                            valid_next = 1'b1;
                            if (!item_reg.dt_zero) begin
                                state_next = (phase_reg == PHASE_HOLD) ? ST_H1 : ST_MOVE;
                            end
                        end
                    end
                    KIND_GOAL: begin
                        goal_open_next      = 1'b1;
                        cancel_pending_next = 1'b0;
                        phase_next          = PHASE_APPROACH;
                        integral_acc_next   = '0;
                        command_next        = item_reg.joint_angle;
                    end
                    KIND_CANCEL: begin
                        cancel_pending_next = 1'b1;
                    end
                    KIND_ACTIVATE: begin
                        active_flag_next = 1'b1;
                    end
                    KIND_DEACTIVATE: begin
                        active_flag_next = 1'b0;
                        if (goal_open_reg) begin
                            event_next     = EVENT_ABORTED;
                            goal_open_next = 1'b0;
                        end
                    end
                    KIND_NOP: begin
                    end
                    default: begin
                    end
                endcase
            end
            ST_MOVE: begin
                state_next = ST_OUT;
                if (phase_reg == PHASE_APPROACH) begin
                    command_next = sat_angle(q48 + mv_s48);
                    if (force23 > thr23) begin
                        phase_next        = PHASE_BACKOFF;
                        backoff_goal_next = sat_angle(q48 + {25'b0, cfg.backoff_distance});
                    end
                end else begin
                    command_next = sat_angle(q48 - mv_s48);
                    if (item_reg.joint_angle >= backoff_goal_reg) begin
                        phase_next = PHASE_HOLD;
                    end
                end
            end
            ST_H1: begin
                state_next = ST_H2;
            end
            ST_H2: begin
                plo_next   = prod_reg[PLO_W-1:0];
                state_next = ST_H3;
            end
            ST_H3: begin
                hi_next    = prod_reg[45:0];
                state_next = ST_H4;
            end
            ST_H4: begin
                // Integral update with the symmetric clamp
                if (acc_sum48 > ilim48) begin
                    integral_acc_next = ANGLE_W'(ilim48);
                end else if (acc_sum48 < -ilim48) begin
                    integral_acc_next = ANGLE_W'(-ilim48);
                end else begin
                    integral_acc_next = ANGLE_W'(acc_sum48);
                end
                state_next = ST_H5;
            end
            ST_H5: begin
                s_next     = s_calc48;
                state_next = ST_H6;
            end
            ST_H6: begin
                s_neg_next = s_reg[WIDE_W-1];
                smag_next  = s_abs[SMAG_W-1:0] >> RAD_PER_G_SHIFT;
                lim_next   = prod_reg[42:20];
                state_next = ST_H7;
            end
            ST_H7: begin
                // Correction opposes the PI sum and is rate limited
                dq_next    = s_neg_reg ? {1'b0, dq_mag} : -{1'b0, dq_mag};
                state_next = ST_H8;
            end
            ST_H8: begin
                command_next = sat_angle(q48 + dq48);
                event_next   = EVENT_NONE;
                if (goal_open_reg && (e_mag_reg < DEADBAND_C)) begin
                    event_next = EVENT_SUCCEEDED;
                    goal_left  = 1'b0;
                end
                if (cancel_pending_reg && goal_left) begin
                    event_next = EVENT_CANCELED;
                    goal_left  = 1'b0;
                end
                goal_open_next = goal_left;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_TDATA_W-ANGLE_W-PHASE_W-EVENT_W){1'b0}},
                                     event_reg, phase_reg, command_reg};
                    m_tuser_next  = valid_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            phase_reg          <= PHASE_APPROACH;
            integral_acc_reg   <= '0;
            command_reg        <= '0;
            active_flag_reg    <= 1'b0;
            goal_open_reg      <= 1'b0;
            cancel_pending_reg <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            state_reg          <= state_next;
            phase_reg          <= phase_next;
            integral_acc_reg   <= integral_acc_next;
            command_reg        <= command_next;
            active_flag_reg    <= active_flag_next;
            goal_open_reg      <= goal_open_next;
            cancel_pending_reg <= cancel_pending_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        backoff_goal_reg <= backoff_goal_next;
        item_reg         <= item_next;
        event_reg        <= event_next;
        valid_reg        <= valid_next;
        prod_reg         <= mul_p;
        e_neg_reg        <= e_neg_next;
        e_mag_reg        <= e_mag_next;
        plo_reg          <= plo_next;
        hi_reg           <= hi_next;
        s_reg            <= s_next;
        smag_reg         <= smag_next;
        s_neg_reg        <= s_neg_next;
        lim_reg          <= lim_next;
        dq_reg           <= dq_next;
        m_tdata_reg      <= m_tdata_next;
        m_tuser_reg      <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[rtl/gripper_contact_force_pi_fsm_core.sv]
// Top level of the gripper contact-force controller: configuration registers,
// the classifying front end with its queue, and the executing back end.
// Depends on gcf_pkg, gcf_front and gcf_back.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake             Contents
//  s_        in         s_tvalid / s_tready   one control tick or goal command
//  m_        out        m_tvalid / m_tready   one result per input transfer
//  cfg_      in         cfg_valid / cfg_ready register index and write data
//
//  An input transfer runs in the back end through idle, execute and output for
//  goal, cancel, activate, deactivate, unused opcodes and ticks that do no update;
//  an approach or backoff tick adds the move state, and a hold tick adds states H1
//  to H8, where five products pass one after another through the single 32 x 32 multiplier.
//  The two-entry queue keeps taking transfers until it is full while the back end
//  works or the result register waits on m_tready; a stalled result holds its data.
//  aresetn is synchronous and active low; it restores the register defaults,
//  empties the queue and puts the controller in approach, inactive, no goal.

module gripper_contact_force_pi_fsm_core #(
    parameter int RAD_PER_G_SHIFT = 13,
    parameter int DEADBAND_FORCE  = 800
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // joint_angle [23:0], grip_force [45:24], tick_time [65:46], zero [71:66]
    input  logic [gcf_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode [2:0]
    input  logic [gcf_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // position_command [23:0], phase [25:24], goal_event [27:26], zero [31:28]
    output logic [gcf_pkg::M_TDATA_W-1:0]   m_tdata,
    // command_valid [0]
    output logic [gcf_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gcf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gcf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gcf_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  pop;
    logic  head_valid;
    item_t head;

    // Registers are always writable; an index past the last register is dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && (cfg_index < CFG_INDEX_W'(NUM_REGS))) begin
            unique case (cfg_index[REG_IDX_W-1:0])
                REG_APPROACH_SPEED:    cfg_next.approach_speed    = $signed(cfg_data[23:0]);
                REG_CONTACT_THRESHOLD: cfg_next.contact_threshold = cfg_data[20:0];
                REG_BACKOFF_DISTANCE:  cfg_next.backoff_distance  = cfg_data[22:0];
                REG_FORCE_TARGET:      cfg_next.force_target      = cfg_data[20:0];
                REG_PROPORTIONAL_GAIN: cfg_next.proportional_gain = cfg_data[23:0];
                REG_INTEGRAL_GAIN:     cfg_next.integral_gain     = cfg_data[23:0];
                REG_INTEGRAL_LIMIT:    cfg_next.integral_limit    = cfg_data[22:0];
                REG_MAX_RATE:          cfg_next.max_rate          = cfg_data[22:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: takes transfers, turns the opcode into a command kind and
    // queues the item so that the back end can run at its own pace.
    gcf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back end: owns the controller state and the result register.
    gcf_back #(
        .RAD_PER_G_SHIFT (RAD_PER_G_SHIFT),
        .DEADBAND_FORCE  (DEADBAND_FORCE)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

[rtl/gcf_checker.sv]
// Port-level checks for the gripper contact-force controller, bound to the top.
// Depends on gcf_pkg and gripper_contact_force_pi_fsm_core.
`timescale 1ns / 1ps

module gcf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [gcf_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [gcf_pkg::S_TUSER_W-1:0]   s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [gcf_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [gcf_pkg::M_TUSER_W-1:0]   m_tuser,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [gcf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [gcf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gcf_pkg::*;

    logic [EVENT_W-1:0] out_event;
    logic [PHASE_W-1:0] out_phase;

    assign out_event = m_tdata[EVENT_LSB +: EVENT_W];
    assign out_phase = m_tdata[PHASE_LSB +: PHASE_W];

    // No result is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result transfer keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Success and cancel come only from an executed tick in hold.
    a_hold_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_event == EVENT_SUCCEEDED || out_event == EVENT_CANCELED)
        |-> m_tuser[0] && (out_phase == PHASE_HOLD))
        else $error("goal ended outside of a hold tick");

    // An abort comes from deactivation, never from a tick.
    a_abort_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_event == EVENT_ABORTED) |-> !m_tuser[0])
        else $error("abort reported on a command tick");

endmodule

bind gripper_contact_force_pi_fsm_core gcf_checker u_gcf_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
